>>> design/ill_pkg.sv
// Shared types, constants and character helpers for the integer literal lexer.
// No dependencies; imported by the channel interfaces and the top level.
package ill_pkg;

    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 4;
    localparam int RADIX_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CHAR_W-1:0]  SEP_RESET   = 8'd95;   // underscore
    localparam logic [VALUE_W-1:0] BIN_TOP     = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] HEX_TOP     = 64'hF000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] DEC_LIMIT_Q = 64'd1844674407370955161;
    localparam logic [3:0]         DEC_LIMIT_R = 4'd5;
    localparam logic [COUNT_W-1:0] HEX_MAX_DIGITS = 7'd16;
    localparam logic [COUNT_W-1:0] BIN_MAX_DIGITS = 7'd64;
    localparam logic [COUNT_W-1:0] DEC_MAX_DIGITS = 7'd64;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LO_E  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] LO_HEX_OFS = 8'h57;   // 'a' - 10
    localparam logic [CHAR_W-1:0] UP_HEX_OFS = 8'h37;   // 'A' - 10

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_ZERO = 5'b00010,
        MODE_DEC  = 5'b00100,
        MODE_HEX  = 5'b01000,
        MODE_BIN  = 5'b10000
    } t_mode;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } t_radix;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 4'd0,
        ST_SEP_START  = 4'd1,
        ST_SEP_DOUBLE = 4'd2,
        ST_SEP_END    = 4'd3,
        ST_TOO_BIG    = 4'd4,
        ST_NO_DIGIT   = 4'd5,
        ST_BAD_DIGIT  = 4'd6,
        ST_BAD_PREFIX = 4'd7,
        ST_FLOAT      = 4'd8
    } t_status;

    localparam logic [0:0] REG_SEPARATOR = 1'b0;   // index bit of the separator register

    function automatic logic is_digit(logic [CHAR_W-1:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_letter(logic [CHAR_W-1:0] c);
        return (c inside {[CH_LO_A:CH_LO_Z]}) || (c inside {[CH_UP_A:CH_UP_Z]});
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c inside {[CH_0:CH_9]}) begin
            t = c - CH_0;
            return {1'b1, t[3:0]};
        end
        if (c inside {[CH_LO_A:CH_LO_F]}) begin
            t = c - LO_HEX_OFS;
            return {1'b1, t[3:0]};
        end
        if (c inside {[CH_UP_A:CH_UP_F]}) begin
            t = c - UP_HEX_OFS;
            return {1'b1, t[3:0]};
        end
        return 5'b0;
    endfunction

endpackage

>>> design/ill_if.sv
// Valid/ready channel interfaces for the lexer: character words in, result words out.
// Depends on ill_pkg for field widths.
interface ill_in_if import ill_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              first_char;

    modport source (output valid, character, first_char, input ready);
    modport sink   (input valid, character, first_char, output ready);
endinterface

interface ill_out_if import ill_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  literal_value;
    logic [RADIX_W-1:0]  radix_kind;
    logic [COUNT_W-1:0]  digit_count;
    logic [STATUS_W-1:0] status;
    logic                ended_by_quote;

    modport source (output valid, literal_value, radix_kind, digit_count, status,
                    ended_by_quote, input ready);
    modport sink   (input valid, literal_value, radix_kind, digit_count, status,
                    ended_by_quote, output ready);
endinterface

>>> design/integer_literal_lexer.sv
// Integer literal lexer: input register, one pass of lexing logic, result register.
// Characters are lexed out of the input register into the result register.
// Throughput: one character per cycle; input stalls while a result word waits unaccepted.
// Reset (i_rst_n, synchronous, active low): lexer idle, separator back to underscore.
// Depends on ill_pkg and the channel interfaces in ill_if.sv.
module integer_literal_lexer import ill_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ill_in_if.sink                i_char,
    ill_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // config
    logic [CHAR_W-1:0] r_sep;

    // input register
    logic              r_in_v;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_first;

    // lexer state
    t_mode              r_mode,  n_mode;
    logic [VALUE_W-1:0] r_acc,   n_acc;
    logic [COUNT_W-1:0] r_cnt,   n_cnt;
    logic               r_sepok, n_sepok;

    // result register
    logic                r_out_v;
    logic [VALUE_W-1:0]  r_out_value;
    logic [RADIX_W-1:0]  r_out_radix;
    logic [COUNT_W-1:0]  r_out_count;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_quote;

    logic                emit;
    logic [VALUE_W-1:0]  res_value;
    t_radix              res_radix;
    logic [COUNT_W-1:0]  res_count;
    t_status             res_status;
    logic                res_quote;

    logic proc_go;
    logic cfg_wr;

    logic [CHAR_W-1:0]  c;
    logic               c_digit, c_letter, c_sep, c_quote, c_float;
    logic               c_prefix_x, c_prefix_b;
    logic [CHAR_W-1:0]  dec_t;
    logic [3:0]         dec_d;
    logic [VALUE_W-1:0] dec_next;
    logic               dec_ovf;
    logic [4:0]         hv;
    logic               rad_hex, rad_dig;
    logic [3:0]         rad_val;
    logic [VALUE_W-1:0] rad_next;
    logic               rad_ovf;
    logic               do_dec;
    t_status            end_st;

    assign proc_go      = r_in_v && (!r_out_v || o_res.ready);
    assign i_char.ready = !r_in_v || proc_go;

    // APB: single register, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SEPARATOR);
    assign prdata = (paddr[2] == REG_SEPARATOR) ? {{(APB_DATA_W-CHAR_W){1'b0}}, r_sep}
                                                : '0;

    // character classification
    always_comb begin
        c          = r_in_char;
        c_digit    = is_digit(c);
        c_letter   = is_letter(c);
        c_sep      = (c == r_sep);
        c_quote    = (c == CH_QUOTE);
        c_float    = (c == CH_DOT) || (c == CH_LO_E) || (c == CH_UP_E);
        c_prefix_x = (c == CH_LO_X) || (c == CH_UP_X);
        c_prefix_b = (c == CH_LO_B) || (c == CH_UP_B);

        dec_t    = c - CH_0;
        dec_d    = dec_t[3:0];
        // acc*10 + d as two shifts and two adds
        dec_next = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                 + {{(VALUE_W-4){1'b0}}, dec_d};
        dec_ovf  = (r_cnt >= DEC_MAX_DIGITS) || (r_acc > DEC_LIMIT_Q)
                 || ((r_acc == DEC_LIMIT_Q) && (dec_d > DEC_LIMIT_R));

        rad_hex = (r_mode == MODE_HEX);
        hv      = hex_val(c);
        if (rad_hex) begin
            rad_dig  = hv[4];
            rad_val  = hv[3:0];
            rad_next = {r_acc[VALUE_W-5:0], rad_val};
            rad_ovf  = ((r_acc & HEX_TOP) != '0) || (r_cnt >= HEX_MAX_DIGITS);
        end else begin
            rad_dig  = (c == CH_0) || (c == CH_1);
            rad_val  = {3'b000, (c == CH_1)};
            rad_next = {r_acc[VALUE_W-2:0], rad_val[0]};
            rad_ovf  = ((r_acc & BIN_TOP) != '0) || (r_cnt >= BIN_MAX_DIGITS);
        end

        if (r_cnt == '0) begin
            end_st = ST_NO_DIGIT;
        end else if (!r_sepok) begin
            end_st = ST_SEP_END;
        end else begin
            end_st = ST_OK;
        end
    end

    // next state and result
    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_sepok = r_sepok;
        emit       = 1'b0;
        res_value  = r_acc;
        res_count  = r_cnt;
        res_status = ST_OK;
        res_quote  = 1'b0;
        do_dec     = 1'b0;

        case (r_mode)
            MODE_HEX: res_radix = RADIX_HEX;
            MODE_BIN: res_radix = RADIX_BIN;
            default:  res_radix = RADIX_DEC;
        endcase

        if (r_in_first) begin
            res_radix = RADIX_DEC;
            if (!c_digit) begin
                emit       = 1'b1;
                res_value  = '0;
                res_count  = '0;
                res_status = ST_BAD_DIGIT;
                n_acc      = '0;
                n_cnt      = '0;
                n_sepok    = 1'b0;
            end else begin
                n_acc   = {{(VALUE_W-4){1'b0}}, dec_d};
                n_cnt   = 7'd1;
                n_sepok = 1'b1;
                n_mode  = (c == CH_0) ? MODE_ZERO : MODE_DEC;
            end
        end else begin
            case (r_mode)
                MODE_ZERO: begin
                    if (c_prefix_x || c_prefix_b) begin
                        n_mode  = c_prefix_x ? MODE_HEX : MODE_BIN;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_sepok = 1'b0;
                    end else if (c_letter) begin
                        emit       = 1'b1;
                        res_status = ST_BAD_PREFIX;
                    end else begin
                        n_mode = MODE_DEC;
                        do_dec = 1'b1;
                    end
                end
                MODE_DEC: do_dec = 1'b1;
                MODE_HEX, MODE_BIN: begin
                    if (rad_dig) begin
                        n_sepok = 1'b1;
                        if (rad_ovf) begin
                            emit       = 1'b1;
                            res_status = ST_TOO_BIG;
                        end else begin
                            n_acc = rad_next;
                            n_cnt = r_cnt + 7'd1;
                        end
                    end else if (c_sep) begin
                        if (!r_sepok) begin
                            emit       = 1'b1;
                            res_status = (r_cnt == '0) ? ST_SEP_START : ST_SEP_DOUBLE;
                        end else begin
                            n_sepok = 1'b0;
                        end
                    end else if (c_letter || (!rad_hex && c_digit)) begin
                        emit       = 1'b1;
                        res_status = ST_BAD_DIGIT;
                    end else begin
                        emit       = 1'b1;
                        res_status = end_st;
                        res_quote  = (end_st == ST_OK) && c_quote;
                    end
                end
                default: ;
            endcase

            if (do_dec) begin
                if (c_digit) begin
                    n_sepok = 1'b1;
                    if (dec_ovf) begin
                        emit       = 1'b1;
                        res_status = ST_TOO_BIG;
                    end else begin
                        n_acc = dec_next;
                        n_cnt = r_cnt + 7'd1;
                    end
                end else if (c_sep) begin
                    if (!r_sepok) begin
                        emit       = 1'b1;
                        res_status = (r_cnt == '0) ? ST_SEP_START : ST_SEP_DOUBLE;
                    end else begin
                        n_sepok = 1'b0;
                    end
                end else if (!r_sepok) begin
                    emit       = 1'b1;
                    res_status = ST_SEP_END;
                end else if (c_float) begin
                    emit       = 1'b1;
                    res_status = ST_FLOAT;
                end else begin
                    emit      = 1'b1;
                    res_quote = c_quote;
                end
            end
        end

        if (emit) begin
            n_mode = MODE_IDLE;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (cfg_wr) begin
            r_sep <= pwdata[CHAR_W-1:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_char.ready) begin
            r_in_v <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char  <= i_char.character;
            r_in_first <= i_char.first_char;
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_sepok <= 1'b0;
        end else if (proc_go) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_sepok <= n_sepok;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (proc_go && emit) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && emit) begin
            r_out_value  <= res_value;
            r_out_radix  <= res_radix;
            r_out_count  <= res_count;
            r_out_status <= res_status;
            r_out_quote  <= res_quote;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.literal_value  = r_out_value;
    assign o_res.radix_kind     = r_out_radix;
    assign o_res.digit_count    = r_out_count;
    assign o_res.status         = r_out_status;
    assign o_res.ended_by_quote = r_out_quote;

    // a result word always leaves the lexer idle
    a_emit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && emit |=> r_mode == MODE_IDLE)
        else $error("lexer not idle after result");

    a_quote_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ended_by_quote |-> o_res.status == ST_OK)
        else $error("quote flag with error status");

    a_ok_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.status == ST_OK) |-> o_res.digit_count != '0)
        else $error("ok result without digits");

    a_hex_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.radix_kind == RADIX_HEX) |-> o_res.digit_count <= HEX_MAX_DIGITS)
        else $error("hex digit count out of range");

endmodule
